[hw/rtl/rv32ex_pkg.sv]
package rv32ex_pkg;

    localparam int XLEN = 32;

    // op class codes
    localparam logic [2:0] OP_ALU    = 3'd0;
    localparam logic [2:0] OP_BRANCH = 3'd1;
    localparam logic [2:0] OP_AUIPC  = 3'd2;
    localparam logic [2:0] OP_JAL    = 3'd3;
    localparam logic [2:0] OP_JALR   = 3'd4;
    localparam logic [2:0] OP_LUI    = 3'd5;
    localparam logic [2:0] OP_OTHER  = 3'd6;

    // alu func3 codes
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SRL  = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // branch func3 codes
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    // forward select bits
    localparam int FWD_MEM_BIT = 0;
    localparam int FWD_WB_BIT  = 1;

    localparam logic [XLEN-1:0] INSTR_BYTES = 32'd4;

    typedef struct packed {
        logic [2:0]      op_class;
        logic [2:0]      func3;
        logic            func7_bit5;
        logic            second_is_imm;
        logic [XLEN-1:0] pc_value;
        logic [XLEN-1:0] immediate;
        logic [XLEN-1:0] rs1_data;
        logic [XLEN-1:0] rs2_data;
        logic [1:0]      src1_forward;
        logic [1:0]      src2_forward;
        logic [XLEN-1:0] mem_forward_data;
        logic [XLEN-1:0] wb_forward_data;
    } instr_t;

    typedef struct packed {
        logic [XLEN-1:0] alu_result;
        logic [XLEN-1:0] next_pc;
        logic            branch_taken;
    } result_t;

    // operands after forwarding and selection
    typedef struct packed {
        logic [2:0]      op_class;
        logic [2:0]      func3;
        logic            func7_bit5;
        logic            second_is_imm;
        logic [XLEN-1:0] pc_value;
        logic [XLEN-1:0] immediate;
        logic [XLEN-1:0] src1;
        logic [XLEN-1:0] opa;
        logic [XLEN-1:0] opb;
    } opnd_t;

    // alu outputs and compare flags
    typedef struct packed {
        logic [2:0]      op_class;
        logic [2:0]      func3;
        logic [XLEN-1:0] alu_value;
        logic            eq;
        logic            lt;
        logic            ltu;
        logic [XLEN-1:0] branch_target;
        logic [XLEN-1:0] jalr_target;
        logic [XLEN-1:0] seq_pc;
    } exec_t;

    function automatic logic [XLEN-1:0] pick_source(
        input logic [1:0]      sel,
        input logic [XLEN-1:0] reg_data,
        input logic [XLEN-1:0] mem_data,
        input logic [XLEN-1:0] wb_data
    );
        logic [XLEN-1:0] value;
        priority if (sel[FWD_MEM_BIT])
        begin
            value = mem_data;
        end
        else if (sel[FWD_WB_BIT])
        begin
            value = wb_data;
        end
        else
        begin
            value = reg_data;
        end
        return value;
    endfunction

endpackage

[hw/rtl/rv32ex_alu.sv]
module rv32ex_alu
    import rv32ex_pkg::*;
(
    input  opnd_t opnd,
    output exec_t exec
);

    logic            do_sub;
    logic [XLEN-1:0] opb_add;
    logic [XLEN-1:0] sum;
    logic [4:0]      shamt;
    logic            lt_s;
    logic            lt_u;
    logic [XLEN-1:0] alu_value;

    assign do_sub  = (opnd.op_class == OP_ALU) && (opnd.func3 == F3_ADD)
                     && opnd.func7_bit5 && !opnd.second_is_imm;
    assign opb_add = do_sub ? ~opnd.opb : opnd.opb;
    assign sum     = opnd.opa + opb_add + {{(XLEN-1){1'b0}}, do_sub};
    assign shamt   = opnd.opb[4:0];
    assign lt_s    = $signed(opnd.opa) < $signed(opnd.opb);
    assign lt_u    = opnd.opa < opnd.opb;

    always_comb
    begin
        if (opnd.op_class == OP_ALU)
        begin
            unique case (opnd.func3)
                F3_ADD:  alu_value = sum;
                F3_SLL:  alu_value = opnd.opa << shamt;
                F3_SLT:  alu_value = {{(XLEN-1){1'b0}}, lt_s};
                F3_SLTU: alu_value = {{(XLEN-1){1'b0}}, lt_u};
                F3_XOR:  alu_value = opnd.opa ^ opnd.opb;
                F3_SRL:  alu_value = opnd.func7_bit5
                                     ? XLEN'($signed(opnd.opa) >>> shamt)
                                     : opnd.opa >> shamt;
                F3_OR:   alu_value = opnd.opa | opnd.opb;
                F3_AND:  alu_value = opnd.opa & opnd.opb;
                default: alu_value = sum;
            endcase
        end
        else
        begin
            alu_value = sum;
        end
    end

    always_comb
    begin
        exec.op_class      = opnd.op_class;
        exec.func3         = opnd.func3;
        exec.alu_value     = alu_value;
        exec.eq            = opnd.opa == opnd.opb;
        exec.lt            = lt_s;
        exec.ltu           = lt_u;
        exec.branch_target = opnd.pc_value + opnd.immediate;
        // jalr clears bit 0 of the target
        exec.jalr_target   = (opnd.src1 + opnd.immediate) & ~{{(XLEN-1){1'b0}}, 1'b1};
        exec.seq_pc        = opnd.pc_value + INSTR_BYTES;
    end

endmodule

[hw/rtl/rv32i_execute_alu_branch.sv]
// RV32I execute stage: forwarding, operand select, alu and branch resolve.
// instr channel: instr_valid / instr_stall carry one decoded instruction per beat
// together with the register read data and both forwarding values.
// result channel: result_valid / result_stall carry alu_result, next_pc and
// branch_taken for each instruction, in order, one beat per instruction.
// an accepted instr beat is registered in s1_reg, then s2_reg, then res_reg,
// and result_valid rises once it reaches res_reg.
// throughput: one instruction per cycle while result_stall is low; three register
// stages (operand select, alu/adders, branch resolve) each hold one beat.
// when result_stall is high the output beat holds; younger beats still move
// up into empty stages, and instr_stall rises only once all three stages
// are full. no beat is lost or repeated under stall.
// reset clears all stage valid bits.
module rv32i_execute_alu_branch
    import rv32ex_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    instr_valid,
    output logic    instr_stall,
    input  instr_t  instr,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic    s1_valid_reg;
    opnd_t   s1_reg;
    opnd_t   s1_next;
    logic    s2_valid_reg;
    exec_t   s2_reg;
    exec_t   s2_next;
    logic    res_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    s1_ready;
    logic    s2_ready;
    logic    s3_ready;
    logic    cmp;
    logic    taken;

    assign s3_ready    = !res_valid_reg || !result_stall;
    assign s2_ready    = !s2_valid_reg || s3_ready;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign instr_stall = !s1_ready;

    // stage 1: forwarding and operand select
    always_comb
    begin
        logic [XLEN-1:0] src1;
        logic [XLEN-1:0] src2;
        src1 = pick_source(instr.src1_forward, instr.rs1_data,
                           instr.mem_forward_data, instr.wb_forward_data);
        src2 = pick_source(instr.src2_forward, instr.rs2_data,
                           instr.mem_forward_data, instr.wb_forward_data);
        s1_next.op_class      = instr.op_class;
        s1_next.func3         = instr.func3;
        s1_next.func7_bit5    = instr.func7_bit5;
        s1_next.second_is_imm = instr.second_is_imm;
        s1_next.pc_value      = instr.pc_value;
        s1_next.immediate     = instr.immediate;
        s1_next.src1          = src1;
        if (instr.op_class == OP_AUIPC || instr.op_class == OP_JAL
            || instr.op_class == OP_JALR)
        begin
            s1_next.opa = instr.pc_value;
        end
        else if (instr.op_class == OP_LUI)
        begin
            s1_next.opa = '0;
        end
        else
        begin
            s1_next.opa = src1;
        end
        if (instr.second_is_imm)
        begin
            s1_next.opb = instr.immediate;
        end
        else if (instr.op_class == OP_JAL || instr.op_class == OP_JALR)
        begin
            s1_next.opb = INSTR_BYTES;
        end
        else
        begin
            s1_next.opb = src2;
        end
    end

    // stage 2: alu and target adders
    rv32ex_alu u_alu (
        .opnd (s1_reg),
        .exec (s2_next)
    );

    // stage 3: branch resolve and next pc
    always_comb
    begin
        unique case (s2_reg.func3)
            F3_BEQ:  cmp = s2_reg.eq;
            F3_BNE:  cmp = !s2_reg.eq;
            F3_BLT:  cmp = s2_reg.lt;
            F3_BGE:  cmp = !s2_reg.lt;
            F3_BLTU: cmp = s2_reg.ltu;
            F3_BGEU: cmp = !s2_reg.ltu;
            default: cmp = 1'b0;
        endcase
        if (s2_reg.op_class == OP_BRANCH)
        begin
            taken                = cmp;
            res_next.alu_result  = {{(XLEN-1){1'b0}}, cmp};
        end
        else
        begin
            taken                = (s2_reg.op_class == OP_JAL) || (s2_reg.op_class == OP_JALR);
            res_next.alu_result  = s2_reg.alu_value;
        end
        if (s2_reg.op_class == OP_JALR)
        begin
            res_next.next_pc = s2_reg.jalr_target;
        end
        else if (taken)
        begin
            res_next.next_pc = s2_reg.branch_target;
        end
        else
        begin
            res_next.next_pc = s2_reg.seq_pc;
        end
        res_next.branch_taken = taken;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= instr_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                res_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && instr_valid)
        begin
            s1_reg <= s1_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

`ifndef SYNTH
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        instr_stall |-> (s1_valid_reg && s2_valid_reg && res_valid_reg))
        else $error("input stalled with an empty stage");

    a_jalr_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_reg.op_class == OP_JALR) |-> !s2_reg.jalr_target[0])
        else $error("jalr target bit 0 set");

    a_jump_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_ready && s2_valid_reg
         && (s2_reg.op_class == OP_JAL || s2_reg.op_class == OP_JALR))
        |=> (result_valid && result.branch_taken))
        else $error("jump not marked taken");
`endif

endmodule
